@@ design/iri_pkg.sv @@
// Package for the image rotation core: shared widths, types and register codes.
// Depends on nothing; used by the interfaces and all modules.
package iri_pkg;

    localparam int PixelW = 24;

    typedef enum logic [2:0] {
        REG_SRC_ROWS = 3'd0,
        REG_SRC_COLS = 3'd1,
        REG_TGT_ROWS = 3'd2,
        REG_TGT_COLS = 3'd3,
        REG_COS      = 3'd4,
        REG_SIN      = 3'd5,
        REG_MODE     = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic       func;
        logic [8:0] pixel_row;
        logic [8:0] pixel_col;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       covered;
    } out_item_t;

endpackage

@@ design/iri_in_if.sv @@
// Input item channel: valid/ready handshake with the load or query payload.
// Depends on iri_pkg.
interface iri_in_if;
    import iri_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ design/iri_out_if.sv @@
// Result item channel: valid/ready handshake with the rotated pixel payload.
// Depends on iri_pkg.
interface iri_out_if;
    import iri_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ design/image_rotate_interp_core.sv @@
// Image rotation core with nearest or bilinear sampling from a banked pixel store.
// A query passes stages for products, coordinates, store read, routing and weights, weighted
// products and sum, round and clip; one item per cycle when the output side keeps up. The
// store is split into four banks by row and column parity so all four bilinear neighbors are
// read in the same cycle. Reset clears configuration and valid and load flags only; the
// store is undefined until loaded. Depends on iri_pkg and the two channel interfaces.
module image_rotate_interp_core #(
    parameter int MAX_SRC_ROWS = 256,
    parameter int MAX_SRC_COLS = 256,
    parameter int FRAC_BITS    = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    iri_in_if.sink      in_ch,
    iri_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import iri_pkg::*;

    localparam int RB = $clog2(MAX_SRC_ROWS);
    localparam int CB = $clog2(MAX_SRC_COLS);
    localparam int HR = (RB > 1) ? RB - 1 : 1;
    localparam int HC = (CB > 1) ? CB - 1 : 1;
    localparam int BANK_DEPTH = ((MAX_SRC_ROWS + 1) / 2) * ((MAX_SRC_COLS + 1) / 2);
    localparam int BAW = HR + HC;
    localparam int F = FRAC_BITS;
    localparam int PW = 29;           // product width (11-bit signed * 16-bit signed) + sum
    localparam int CW = PW + 2 + 13;  // coordinate width
    localparam int WW = F + 1;        // weight width (0..2^F)
    localparam int DEPTH = 6;

    // ---------------- configuration ----------------
    logic [8:0]  src_rows_reg, src_cols_reg;
    logic [9:0]  tgt_rows_reg, tgt_cols_reg;
    logic signed [15:0] cos_reg, sin_reg;
    logic        mode_reg;
    reg_idx_t    widx;

    assign pready = 1'b1;
    assign widx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            src_rows_reg <= 9'd256;
            src_cols_reg <= 9'd256;
            tgt_rows_reg <= 10'd256;
            tgt_cols_reg <= 10'd256;
            cos_reg      <= 16'sd16384;
            sin_reg      <= 16'sd0;
            mode_reg     <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (widx)
                REG_SRC_ROWS: src_rows_reg <= pwdata[8:0];
                REG_SRC_COLS: src_cols_reg <= pwdata[8:0];
                REG_TGT_ROWS: tgt_rows_reg <= pwdata[9:0];
                REG_TGT_COLS: tgt_cols_reg <= pwdata[9:0];
                REG_COS:      cos_reg      <= pwdata[15:0];
                REG_SIN:      sin_reg      <= pwdata[15:0];
                REG_MODE:     mode_reg     <= pwdata[0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (widx)
            REG_SRC_ROWS: prdata = {23'd0, src_rows_reg};
            REG_SRC_COLS: prdata = {23'd0, src_cols_reg};
            REG_TGT_ROWS: prdata = {22'd0, tgt_rows_reg};
            REG_TGT_COLS: prdata = {22'd0, tgt_cols_reg};
            REG_COS:      prdata = {{16{cos_reg[15]}}, cos_reg};
            REG_SIN:      prdata = {{16{sin_reg[15]}}, sin_reg};
            REG_MODE:     prdata = {31'd0, mode_reg};
            default:      prdata = '0;
        endcase
    end

    // Effective source size, clamped to the store.
    logic [12:0] rows_eff, cols_eff;
    assign rows_eff = (13'(src_rows_reg) > 13'(MAX_SRC_ROWS)) ? 13'(MAX_SRC_ROWS)
                                                               : 13'(src_rows_reg);
    assign cols_eff = (13'(src_cols_reg) > 13'(MAX_SRC_COLS)) ? 13'(MAX_SRC_COLS)
                                                               : 13'(src_cols_reg);

    // ---------------- pipeline control ----------------
    // Stall only when the last stage holds an unaccepted result.
    logic [DEPTH-1:0] v_reg;
    logic             adv;
    assign adv = !(v_reg[DEPTH-1] && !out_ch.ready);
    assign in_ch.ready = adv;

    logic acc;
    assign acc = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[DEPTH-2:0], acc && in_ch.data.func};
    end

    // ---------------- stage 1: products ----------------
    logic signed [10:0] di, dj;
    assign di = $signed({1'b0, in_ch.data.pixel_row, 1'b0}) - $signed({1'b0, tgt_rows_reg});
    assign dj = $signed({1'b0, in_ch.data.pixel_col, 1'b0}) - $signed({1'b0, tgt_cols_reg});

    logic signed [PW-1:0] pdc_reg, pds_reg, pjc_reg, pjs_reg;
    always_ff @(posedge clk) begin
        if (adv)
        begin
            pdc_reg <= PW'(di * cos_reg);
            pds_reg <= PW'(di * sin_reg);
            pjc_reg <= PW'(dj * cos_reg);
            pjs_reg <= PW'(dj * sin_reg);
        end
    end

    // ---------------- stage 2: coordinates and inside test ----------------
    logic signed [PW-1:0] sx, sy;
    logic signed [CW-1:0] x_c, y_c, xlim, ylim;
    assign sx = pdc_reg - pjs_reg;
    assign sy = pds_reg + pjc_reg;

    function automatic logic signed [CW-1:0] to_coord(input logic signed [PW-1:0] v);
        logic signed [CW-1:0] w;
        w = CW'(v);
        if (F >= 15)
            return w <<< (F - 15);
        else
            return w >>> (15 - F);
    endfunction

    assign x_c  = to_coord(sx) + (CW'(rows_eff >> 1) <<< F);
    assign y_c  = to_coord(sy) + (CW'(cols_eff >> 1) <<< F);
    assign xlim = (CW'(rows_eff) - CW'(1)) <<< F;
    assign ylim = (CW'(cols_eff) - CW'(1)) <<< F;

    logic          in_ok;
    assign in_ok = (rows_eff != 0) && (cols_eff != 0) && (x_c >= 0) && (y_c >= 0)
                   && (x_c <= xlim) && (y_c <= ylim);

    logic [RB-1:0] r1, r2;
    logic [CB-1:0] c1, c2;
    logic [F-1:0]  fx, fy;
    logic [12:0]   rmax, cmax, xi, yi, xn, yn;
    assign rmax = rows_eff - 13'd1;
    assign cmax = cols_eff - 13'd1;
    assign xi   = 13'(x_c >>> F);
    assign yi   = 13'(y_c >>> F);
    assign xn   = 13'((x_c + CW'(1 <<< (F - 1))) >>> F);
    assign yn   = 13'((y_c + CW'(1 <<< (F - 1))) >>> F);
    assign fx   = x_c[F-1:0];
    assign fy   = y_c[F-1:0];

    logic [12:0] ra, rb_, ca, cb_;
    always_comb begin
        if (!mode_reg)
        begin
            ra  = (xn > rmax) ? rmax : xn;
            ca  = (yn > cmax) ? cmax : yn;
            rb_ = ra;
            cb_ = ca;
        end
        else
        begin
            ra  = xi;
            ca  = yi;
            rb_ = (xi + 13'd1 > rmax) ? rmax : xi + 13'd1;
            cb_ = (yi + 13'd1 > cmax) ? cmax : yi + 13'd1;
        end
    end
    assign r1 = RB'(ra);
    assign r2 = RB'(rb_);
    assign c1 = CB'(ca);
    assign c2 = CB'(cb_);

    logic [RB-1:0] r1_reg, r2_reg;
    logic [CB-1:0] c1_reg, c2_reg;
    logic [F-1:0]  fx_reg, fy_reg;
    logic          in_reg, bil_reg;
    always_ff @(posedge clk) begin
        if (adv)
        begin
            r1_reg  <= r1;
            r2_reg  <= r2;
            c1_reg  <= c1;
            c2_reg  <= c2;
            fx_reg  <= mode_reg ? fx : '0;
            fy_reg  <= mode_reg ? fy : '0;
            in_reg  <= in_ok;
            bil_reg <= mode_reg;
        end
    end

    // ---------------- stage 3: banked store read ----------------
    // Bank index is {row parity, column parity}; each bank sees exactly one
    // row and one column from the pair (r1,r2) and (c1,c2).
    logic [PixelW-1:0] bank0 [BANK_DEPTH];
    logic [PixelW-1:0] bank1 [BANK_DEPTH];
    logic [PixelW-1:0] bank2 [BANK_DEPTH];
    logic [PixelW-1:0] bank3 [BANK_DEPTH];

    function automatic logic [BAW-1:0] baddr(input logic [RB-1:0] r, input logic [CB-1:0] c);
        return BAW'(BAW'(r >> 1) * BAW'((MAX_SRC_COLS + 1) / 2) + BAW'(c >> 1));
    endfunction

    logic          ld;
    logic [1:0]    ld_bank;
    logic [BAW-1:0] ld_addr;
    assign ld = acc && !in_ch.data.func
                && (32'(in_ch.data.pixel_row) < MAX_SRC_ROWS)
                && (32'(in_ch.data.pixel_col) < MAX_SRC_COLS);
    assign ld_bank = {in_ch.data.pixel_row[0], in_ch.data.pixel_col[0]};
    assign ld_addr = baddr(RB'(in_ch.data.pixel_row), CB'(in_ch.data.pixel_col));

    // A load is registered in ld_reg and then written to its bank, ahead of the stage where
    // queries read the store, so every query sees exactly the loads that came before it.
    logic              ld_reg;
    logic [1:0]        ld_bank_reg;
    logic [BAW-1:0]    ld_addr_reg;
    logic [PixelW-1:0] ld_data_reg;
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            ld_reg <= 1'b0;
        else if (adv)
            ld_reg <= ld;
    end

    always_ff @(posedge clk) begin
        if (adv)
        begin
            ld_bank_reg <= ld_bank;
            ld_addr_reg <= ld_addr;
            ld_data_reg <= {in_ch.data.red_in, in_ch.data.green_in, in_ch.data.blue_in};
        end
    end

    // Per bank: which row and column of the neighbor set it serves.
    logic [RB-1:0] br [4];
    logic [CB-1:0] bc [4];
    always_comb begin
        for (int b = 0; b < 4; b++)
        begin
            br[b] = (r1_reg[0] == b[1]) ? r1_reg : r2_reg;
            bc[b] = (c1_reg[0] == b[0]) ? c1_reg : c2_reg;
        end
    end

    logic [PixelW-1:0] q_reg [4];
    always_ff @(posedge clk) begin
        if (adv && ld_reg && ld_bank_reg == 2'd0) bank0[ld_addr_reg] <= ld_data_reg;
        if (adv && ld_reg && ld_bank_reg == 2'd1) bank1[ld_addr_reg] <= ld_data_reg;
        if (adv && ld_reg && ld_bank_reg == 2'd2) bank2[ld_addr_reg] <= ld_data_reg;
        if (adv && ld_reg && ld_bank_reg == 2'd3) bank3[ld_addr_reg] <= ld_data_reg;
        if (adv)
        begin
            q_reg[0] <= bank0[baddr(br[0], bc[0])];
            q_reg[1] <= bank1[baddr(br[1], bc[1])];
            q_reg[2] <= bank2[baddr(br[2], bc[2])];
            q_reg[3] <= bank3[baddr(br[3], bc[3])];
        end
    end

    logic [RB-1:0] r1_3_reg, r2_3_reg;
    logic [CB-1:0] c1_3_reg, c2_3_reg;
    logic [F-1:0]  fx3_reg, fy3_reg;
    logic          in3_reg, bil3_reg;
    always_ff @(posedge clk) begin
        if (adv)
        begin
            r1_3_reg <= r1_reg;
            r2_3_reg <= r2_reg;
            c1_3_reg <= c1_reg;
            c2_3_reg <= c2_reg;
            fx3_reg  <= fx_reg;
            fy3_reg  <= fy_reg;
            in3_reg  <= in_reg;
            bil3_reg <= bil_reg;
        end
    end

    // ---------------- stage 4: route pixels, weights ----------------
    function automatic logic [1:0] bsel(input logic rp, input logic cp);
        return {rp, cp};
    endfunction

    logic [PixelW-1:0] p11, p21, p12, p22;
    assign p11 = q_reg[bsel(r1_3_reg[0], c1_3_reg[0])];
    assign p21 = q_reg[bsel(r2_3_reg[0], c1_3_reg[0])];
    assign p12 = q_reg[bsel(r1_3_reg[0], c2_3_reg[0])];
    assign p22 = q_reg[bsel(r2_3_reg[0], c2_3_reg[0])];

    logic [WW-1:0] gx, gy, fxw, fyw;
    assign fxw = WW'(fx3_reg);
    assign fyw = WW'(fy3_reg);
    assign gx  = WW'(1 << F) - fxw;
    assign gy  = WW'(1 << F) - fyw;

    logic [2*WW-1:0]   w_reg [4];
    logic [PixelW-1:0] p_reg [4];
    logic              in4_reg;
    always_ff @(posedge clk) begin
        if (adv)
        begin
            w_reg[0] <= gx * gy;
            w_reg[1] <= fxw * gy;
            w_reg[2] <= gx * fyw;
            w_reg[3] <= fxw * fyw;
            p_reg[0] <= p11;
            p_reg[1] <= bil3_reg ? p21 : p11;
            p_reg[2] <= bil3_reg ? p12 : p11;
            p_reg[3] <= bil3_reg ? p22 : p11;
            in4_reg  <= in3_reg;
        end
    end

    // ---------------- stage 5: weighted products ----------------
    localparam int MW = 2 * WW + 8;
    logic [MW-1:0] m_reg [4][3];
    logic          in5_reg;
    always_ff @(posedge clk) begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
                for (int c = 0; c < 3; c++)
                    m_reg[k][c] <= MW'(w_reg[k] * p_reg[k][16-8*c +: 8]);
            in5_reg <= in4_reg;
        end
    end

    // ---------------- stage 6: sum, round, clip ----------------
    localparam int SW = MW + 2;
    logic [SW-1:0] s [3];
    logic [7:0]    ch [3];
    always_comb begin
        for (int c = 0; c < 3; c++)
        begin
            s[c] = SW'(m_reg[0][c]) + SW'(m_reg[1][c]) + SW'(m_reg[2][c]) + SW'(m_reg[3][c])
                   + (SW'(1) << (2 * F - 1));
            s[c] = s[c] >> (2 * F);
            ch[c] = (s[c] > SW'(255)) ? 8'd255 : s[c][7:0];
        end
    end

    out_item_t res_reg;
    always_ff @(posedge clk) begin
        if (adv)
        begin
            res_reg.red_out   <= in5_reg ? ch[0] : 8'd0;
            res_reg.green_out <= in5_reg ? ch[1] : 8'd0;
            res_reg.blue_out  <= in5_reg ? ch[2] : 8'd0;
            res_reg.covered   <= in5_reg;
        end
    end

    assign out_ch.valid = v_reg[DEPTH-1];
    assign out_ch.data  = res_reg;

    // ---------------- assertions ----------------
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(res_reg)))
        else $error("result changed while stalled");
    a_no_take_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
        else $error("input taken while pipeline stalled");
    a_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !res_reg.covered) |-> (res_reg.red_out == 8'd0
            && res_reg.green_out == 8'd0 && res_reg.blue_out == 8'd0))
        else $error("uncovered pixel not zero");

endmodule

@@ tb/sv/image_rotate_interp_core_tb.sv @@
// Self-checking testbench for image_rotate_interp_core: loads source images, queries
// rotated pixels under many register settings and checks each result item in order.
// Depends on iri_pkg, iri_in_if, iri_out_if and the core itself.
module image_rotate_interp_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import iri_pkg::*;

    localparam int StoreRows = 256;
    localparam int StoreCols = 256;
    localparam int Frac      = 14;
    localparam longint CycleLimit = 3000000;

    class rotation_checker;
        int unsigned src_rows, src_cols, tgt_rows, tgt_cols, mode;
        longint      cos_q, sin_q;
        bit [23:0]   pixels [StoreRows*StoreCols];
        out_item_t   expected_pixels [$];
        int          errors;

        function new();
            src_rows = 256;
            src_cols = 256;
            tgt_rows = 256;
            tgt_cols = 256;
            cos_q    = 16384;
            sin_q    = 0;
            mode     = 0;
            errors   = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [31:0] v);
            case (idx)
                REG_SRC_ROWS: src_rows = v[8:0];
                REG_SRC_COLS: src_cols = v[8:0];
                REG_TGT_ROWS: tgt_rows = v[9:0];
                REG_TGT_COLS: tgt_cols = v[9:0];
                REG_COS:      cos_q = longint'($signed(v[15:0]));
                REG_SIN:      sin_q = longint'($signed(v[15:0]));
                REG_MODE:     mode = v[0];
                default: ;
            endcase
        endfunction

        function longint chan(bit [23:0] p, int k);
            return longint'((p >> (16 - 8 * k)) & 24'hFF);
        endfunction

        function out_item_t rotate_pixel(longint prow, longint pcol);
            longint    rows, cols, one, di, dj, x, y, r, c, x1, y1, x2, y2;
            longint    fx, fy, gx, gy, s;
            bit [23:0] p11, p21, p12, p22;
            bit [7:0]  ch [3];
            out_item_t res;
            res  = '0;
            rows = (src_rows > StoreRows) ? StoreRows : src_rows;
            cols = (src_cols > StoreCols) ? StoreCols : src_cols;
            one  = longint'(1) << Frac;
            di   = 2 * prow - longint'(tgt_rows);
            dj   = 2 * pcol - longint'(tgt_cols);
            // Products carry one fraction bit too many; drop it rounding toward minus infinity.
            x = ((di * cos_q - dj * sin_q) >>> 1) + (rows >>> 1) * one;
            y = ((di * sin_q + dj * cos_q) >>> 1) + (cols >>> 1) * one;
            if (rows < 1 || cols < 1 || x < 0 || y < 0 ||
                x > (rows - 1) * one || y > (cols - 1) * one)
                return res;
            if (mode == 0) begin
                r = (x + (one >>> 1)) >>> Frac;
                c = (y + (one >>> 1)) >>> Frac;
                if (r > rows - 1) r = rows - 1;
                if (c > cols - 1) c = cols - 1;
                p11 = pixels[r * StoreCols + c];
                for (int k = 0; k < 3; k++)
                    ch[k] = 8'(chan(p11, k));
            end
            else begin
                x1 = x >>> Frac;
                y1 = y >>> Frac;
                fx = x & (one - 1);
                fy = y & (one - 1);
                gx = one - fx;
                gy = one - fy;
                x2 = (x1 + 1 > rows - 1) ? rows - 1 : x1 + 1;
                y2 = (y1 + 1 > cols - 1) ? cols - 1 : y1 + 1;
                p11 = pixels[x1 * StoreCols + y1];
                p21 = pixels[x2 * StoreCols + y1];
                p12 = pixels[x1 * StoreCols + y2];
                p22 = pixels[x2 * StoreCols + y2];
                for (int k = 0; k < 3; k++) begin
                    s = gx * gy * chan(p11, k) + fx * gy * chan(p21, k)
                      + gx * fy * chan(p12, k) + fx * fy * chan(p22, k);
                    s = (s + (longint'(1) << (2 * Frac - 1))) >>> (2 * Frac);
                    ch[k] = (s > 255) ? 8'd255 : s[7:0];
                end
            end
            res.red_out   = ch[0];
            res.green_out = ch[1];
            res.blue_out  = ch[2];
            res.covered   = 1'b1;
            return res;
        endfunction

        function void note_item(in_item_t it);
            if (!it.func) begin
                if (it.pixel_row < StoreRows && it.pixel_col < StoreCols)
                    pixels[it.pixel_row * StoreCols + it.pixel_col] =
                        {it.red_in, it.green_in, it.blue_in};
            end
            else
                expected_pixels.push_back(rotate_pixel(it.pixel_row, it.pixel_col));
        endfunction

        function void check_pixel(out_item_t got);
            out_item_t want;
            if (expected_pixels.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result item %h", got);
                return;
            end
            want = expected_pixels.pop_front();
            if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
                got.blue_out !== want.blue_out || got.covered !== want.covered) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: want r=%0d g=%0d b=%0d c=%0d, got r=%0d g=%0d b=%0d c=%0d",
                             want.red_out, want.green_out, want.blue_out, want.covered,
                             got.red_out, got.green_out, got.blue_out, got.covered);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    iri_in_if  in_ch ();
    iri_out_if out_ch ();

    image_rotate_interp_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    rotation_checker sb = new();
    bit              written [StoreRows*StoreCols];
    bit              calm;
    int              query_count;
    longint          cycles;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_ch.ready <= calm || ($urandom_range(99) >= 10);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_pixel(out_ch.data);
    end

    task automatic send(in_item_t it);
        if (!calm && $urandom_range(99) < 10) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_item(it);
    endtask

    task automatic load_pixel(int r, int c);
        in_item_t it;
        it.func      = 1'b0;
        it.pixel_row = 9'(r);
        it.pixel_col = 9'(c);
        it.red_in    = 8'($urandom_range(255));
        it.green_in  = 8'($urandom_range(255));
        it.blue_in   = 8'($urandom_range(255));
        send(it);
        if (r < StoreRows && c < StoreCols)
            written[r * StoreCols + c] = 1'b1;
    endtask

    task automatic query(int r, int c);
        in_item_t it;
        it.func      = 1'b1;
        it.pixel_row = 9'(r);
        it.pixel_col = 9'(c);
        it.red_in    = 8'($urandom_range(255));
        it.green_in  = 8'($urandom_range(255));
        it.blue_in   = 8'($urandom_range(255));
        send(it);
        query_count++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (sb.expected_pixels.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic apb_write(reg_idx_t idx, logic [31:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    // Changes every register once the core is idle, then loads any source entry
    // the new size can read that has never been written.
    task automatic configure(int sr, int sc, int tr, int tc, int cq, int sq, int m);
        int er, ec;
        wait_drained();
        apb_write(REG_SRC_ROWS, sr);
        apb_write(REG_SRC_COLS, sc);
        apb_write(REG_TGT_ROWS, tr);
        apb_write(REG_TGT_COLS, tc);
        apb_write(REG_COS, cq);
        apb_write(REG_SIN, sq);
        apb_write(REG_MODE, m);
        er = (sb.src_rows > StoreRows) ? StoreRows : sb.src_rows;
        ec = (sb.src_cols > StoreCols) ? StoreCols : sb.src_cols;
        for (int r = 0; r < er; r++)
            for (int c = 0; c < ec; c++)
                if (!written[r * StoreCols + c])
                    load_pixel(r, c);
    endtask

    task automatic random_item();
        int pick, er, ec, tr, tc;
        pick = $urandom_range(99);
        er = (sb.src_rows > StoreRows) ? StoreRows : sb.src_rows;
        ec = (sb.src_cols > StoreCols) ? StoreCols : sb.src_cols;
        tr = (sb.tgt_rows > 512) ? 512 : sb.tgt_rows;
        tc = (sb.tgt_cols > 512) ? 512 : sb.tgt_cols;
        if (pick < 15 && er > 0 && ec > 0)
            load_pixel($urandom_range(er - 1), $urandom_range(ec - 1));
        else if (pick < 18)
            load_pixel($urandom_range(256, 511), $urandom_range(511));
        else if ($urandom_range(3) == 0)
            query($urandom_range(511), $urandom_range(511));
        else
            query($urandom_range(tr - 1), $urandom_range(tc - 1));
    endtask

    initial
    begin
        int sr, sc, tr, tc, cq, sq, phase;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        calm         = 1'b0;
        cycles       = 0;
        query_count  = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Identity map on a small image, nearest then bilinear, corners and beyond.
        configure(4, 4, 4, 4, 16384, 0, 0);
        query(0, 0);
        query(3, 3);
        query(2, 1);
        query(4, 0);
        configure(4, 4, 4, 4, 16384, 0, 1);
        query(3, 3);
        query(3, 0);
        query(1, 2);
        // Forty-five degrees gives fractional coordinates for the blend.
        configure(5, 7, 8, 8, 11585, 11585, 1);
        query(4, 4);
        query(3, 5);
        query(0, 0);
        configure(6, 3, 9, 5, -16384, 16384, 0);
        query(511, 511);
        query(4, 2);
        query(5, 3);
        // An empty source makes every query a zero pixel.
        configure(0, 5, 4, 4, 16384, 0, 1);
        query(2, 2);
        // Oversized row count is clamped to the store size.
        configure(511, 1, 512, 2, 16384, 0, 1);
        query(511, 1);
        query(256, 0);
        query(300, 1);
        // Oversized column count is clamped the same way.
        configure(1, 300, 2, 512, -16384, 0, 0);
        query(1, 511);
        query(0, 0);
        load_pixel(300, 511);
        load_pixel(5, 400);
        query(1, 256);

        phase = 0;
        while (query_count < 140) begin
            calm = (phase == 1);
            case ($urandom_range(9))
                0: begin
                    sr = $urandom_range(250, 511);
                    sc = 1;
                end
                1: begin
                    sr = 1;
                    sc = $urandom_range(200, 300);
                end
                2: begin
                    sr = $urandom_range(0, 1);
                    sc = $urandom_range(0, 9);
                end
                default: begin
                    sr = $urandom_range(1, 10);
                    sc = $urandom_range(1, 10);
                end
            endcase
            tr = $urandom_range(1) ? $urandom_range(1, 512) : (sr % 257) + $urandom_range(1, 4);
            tc = $urandom_range(1) ? $urandom_range(1, 512) : (sc % 257) + $urandom_range(1, 4);
            case ($urandom_range(3))
                0: begin
                    cq = $urandom_range(1) ? 16384 : -16384;
                    sq = 0;
                end
                1: begin
                    cq = $urandom_range(65535);
                    sq = $urandom_range(65535);
                end
                default: begin
                    cq = int'($urandom_range(32768)) - 16384;
                    sq = int'($urandom_range(32768)) - 16384;
                end
            endcase
            configure(sr, sc, tr, tc, cq, sq, $urandom_range(1));
            repeat ($urandom_range(40, 70)) random_item();
            phase++;
        end
        calm = 1'b0;

        wait_drained();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
